@@ rtl/core/assert_macros.svh @@
// Assertion helpers included by sdp_parse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sdp_pkg.sv @@
`timescale 1ns / 1ps

package sdp_pkg;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic [30:0] ACC_MAX   = 31'h7FFF_FFFF;
  localparam logic [31:0] YEAR_BASE = 32'd1900;

  typedef enum logic [2:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOND,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [31:0] year;
    logic [30:0] month;
    logic [30:0] day;
    logic [30:0] hour;
    logic [30:0] minute;
    logic [30:0] second;
  } fields_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
    logic       no_char;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } stage_t;

  typedef struct packed {
    logic    status;
    fields_t fields;
  } result_t;

  localparam fields_t FIELDS_RESET = '{
    year:   32'd0,
    month:  31'd0,
    day:    31'd1,
    hour:   31'd0,
    minute: 31'd0,
    second: 31'd0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_DASH) || (c == CH_SPACE) || (c == CH_COLON) ||
           (c == CH_DOT) || (c == CH_NEWLINE) || (c == CH_NUL);
  endfunction

  // acc * 10 + d, clamped to the 31-bit maximum
  function automatic logic [30:0] accumulate(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] wide;
    wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
    if (wide > {4'd0, ACC_MAX}) begin
      return ACC_MAX;
    end
    return wide[30:0];
  endfunction

  function automatic fields_t close_field(input phase_t ph, input logic [30:0] acc,
                                          input fields_t f);
    fields_t r;
    r = f;
    unique case (ph)
      PH_YEAR:   r.year   = {1'b0, acc} - YEAR_BASE;
      PH_MONTH:  r.month  = (acc == '0) ? 31'd0 : acc - 31'd1;
      PH_DAY:    r.day    = (acc == '0) ? 31'd1 : acc;
      PH_HOUR:   r.hour   = acc;
      PH_MINUTE: r.minute = acc;
      PH_SECOND: r.second = acc;
      default:   r = f;
    endcase
    return r;
  endfunction

  function automatic phase_t next_phase(input phase_t ph);
    if (ph == PH_DONE) begin
      return PH_DONE;
    end
    return phase_t'(ph + 3'd1);
  endfunction

endpackage

@@ rtl/core/sql_datetime_parser.sv @@
`timescale 1ns / 1ps

// SQL-style date-time string parser. Feed the string one byte per request on the
// input channel (char_code), mark the final request with is_last; a request with
// no_char set carries no byte and, with is_last, ends a possibly empty string.
// Digits build a saturating decimal value; each of - space : . newline NUL closes
// the next field in the order year, month, day, hour, minute, second, and the
// string end closes the open field. One result comes out per string: status 0
// with year minus 1900, month minus one (0 read as 1), day (0 read as 1), hour,
// minute and second; or status 1 with all fields zero when any other byte was
// seen. Missing fields read month 0, day 1, time 0. The block takes one request
// every clock cycle, with no bubbles but for a closing request held as below;
// the figure is set by the per-byte state update (multiply-by-ten add plus
// field store), combinational between the input and result registers. A closing
// request leaves the input register as its result enters the result register;
// the input keeps flowing while a finished result waits to be taken; only a
// closing request waits, and only while the result register is still full.
module sql_datetime_parser
  import sdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               is_last,
  input  logic               no_char,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic signed [31:0] year_since_1900,
  output logic [30:0]        month_index,
  output logic [30:0]        day_of_month,
  output logic [30:0]        hour_value,
  output logic [30:0]        minute_value,
  output logic [30:0]        second_value
);

  req_t    req_in;
  stage_t  stage;
  logic    advance;
  logic    res_load;
  logic    out_free;
  result_t res_next;
  result_t res;

  assign req_in.char_code = char_code;
  assign req_in.is_last   = is_last;
  assign req_in.no_char   = no_char;

  // Input register: holds one request for the parse step.
  sdp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_in   (req_in),
    .advance  (advance),
    .stage    (stage)
  );

  // Parse step: field state, accumulator and the closing logic.
  sdp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .advance  (advance),
    .res_load (res_load),
    .res      (res_next)
  );

  // Result register: decouples the output handshake from parsing.
  sdp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_next  (res_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_free  (out_free),
    .res       (res)
  );

  assign status          = res.status;
  assign year_since_1900 = $signed(res.fields.year);
  assign month_index     = res.fields.month;
  assign day_of_month    = res.fields.day;
  assign hour_value      = res.fields.hour;
  assign minute_value    = res.fields.minute;
  assign second_value    = res.fields.second;

endmodule

@@ rtl/core/sdp_in_stage.sv @@
`timescale 1ns / 1ps

module sdp_in_stage
  import sdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  req_t   req_in,
  input  logic   advance,
  output stage_t stage
);

  logic take;

  // Refill when the register is empty or the held request moves on this cycle.
  assign in_ready = !stage.valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (take) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (take) begin
      stage.req <= req_in;
    end
  end

endmodule

@@ rtl/core/sdp_parse.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdp_parse
  import sdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  stage_t  stage,
  input  logic    out_free,
  output logic    advance,
  output logic    res_load,
  output result_t res
);

  phase_t      phase, phase_next, ph1;
  logic [30:0] accumulator, accumulator_next, acc1;
  fields_t     fields, fields_next, f1, f2;
  logic        error_seen, error_seen_next, err1;
  logic [7:0]  c;
  logic [3:0]  digit;
  logic        state_clear;
  logic        day_ok;
  logic        stalled;

  assign c     = stage.req.char_code;
  assign digit = 4'(c - CH_ZERO);

  // Only a closing request needs room in the result register.
  assign advance  = stage.valid && (!stage.req.is_last || out_free);
  assign res_load = advance && stage.req.is_last;

  always_comb begin
    ph1  = phase;
    acc1 = accumulator;
    f1   = fields;
    err1 = error_seen;
    if (!stage.req.no_char && !error_seen) begin
      priority if (is_digit(c)) begin
        acc1 = accumulate(accumulator, digit);
      end else if (is_sep(c)) begin
        f1   = close_field(phase, accumulator, fields);
        ph1  = next_phase(phase);
        acc1 = '0;
      end else begin
        err1 = 1'b1;
      end
    end

    // end of string closes the open field
    f2         = close_field(ph1, acc1, f1);
    res.status = err1;
    res.fields = err1 ? '0 : f2;

    phase_next       = phase;
    accumulator_next = accumulator;
    fields_next      = fields;
    error_seen_next  = error_seen;
    if (advance) begin
      if (stage.req.is_last) begin
        phase_next       = PH_YEAR;
        accumulator_next = '0;
        fields_next      = FIELDS_RESET;
        error_seen_next  = 1'b0;
      end else begin
        phase_next       = ph1;
        accumulator_next = acc1;
        fields_next      = f1;
        error_seen_next  = err1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_YEAR;
      accumulator <= '0;
      fields      <= FIELDS_RESET;
      error_seen  <= 1'b0;
    end else begin
      phase       <= phase_next;
      accumulator <= accumulator_next;
      fields      <= fields_next;
      error_seen  <= error_seen_next;
    end
  end

  assign state_clear = (phase == PH_YEAR) && (accumulator == '0) && !error_seen &&
                       (fields == FIELDS_RESET);
  assign day_ok      = res.fields.day != '0;
  assign stalled     = stage.valid && !advance;

  `ASSERT_NEXT(a_clear_after_last, clk, rst, res_load, state_clear, "state not cleared")
  `ASSERT_IMPLIES(a_day_nonzero, clk, rst, res_load && !res.status, day_ok, "day is zero")
  `ASSERT_IMPLIES(a_stall_only_last, clk, rst, stalled, stage.req.is_last, "open request stalled")

endmodule

@@ rtl/core/sdp_out_stage.sv @@
`timescale 1ns / 1ps

module sdp_out_stage
  import sdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_next,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    out_free,
  output result_t res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sdp_pkg::*;

  localparam int STALL_MAX   = 16;
  localparam int LONG_HOLD   = 300;   // receiver hold-off that backs the block up
  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 20;    // idle tail after the final drain; allow plenty
  localparam int RANDOM_REQS = 1100;
  localparam int SCRIPT_LEN  = 23;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         char_code = 8'd0;
  logic               is_last = 1'b0;
  logic               no_char = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic signed [31:0] year_since_1900;
  logic [30:0]        month_index;
  logic [30:0]        day_of_month;
  logic [30:0]        hour_value;
  logic [30:0]        minute_value;
  logic [30:0]        second_value;

  sql_datetime_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .is_last(is_last),
    .no_char(no_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .year_since_1900(year_since_1900),
    .month_index(month_index),
    .day_of_month(day_of_month),
    .hour_value(hour_value),
    .minute_value(minute_value),
    .second_value(second_value)
  );

  // One request of a string: the byte plus its end and no-byte marks.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       none;
  } text_req_t;

  // Directed row; when typed is set, want holds the hand-written date.
  typedef struct packed {
    text_req_t req;
    logic      typed;
    result_t   want;
  } script_row_t;

  // Parse state mirrored by the bench.
  phase_t      next_field = PH_YEAR;
  logic [30:0] digits_acc = '0;
  fields_t     parsed     = FIELDS_RESET;
  logic        bad_char   = 1'b0;

  result_t     dates_due[$];   // dates still owed by the block, oldest first
  text_req_t   text[$];        // string being composed for the random part
  int          errors     = 0;
  int          dates_seen = 0;
  int          reqs_sent  = 0;
  int          quiet      = 0;
  int          send_burst = 0;
  int          take_burst = 0;

  function automatic result_t date_of(input logic st, input logic [31:0] yr,
                                      input logic [30:0] mo, input logic [30:0] dy,
                                      input logic [30:0] hr, input logic [30:0] mi,
                                      input logic [30:0] se);
    result_t r;
    r.status        = st;
    r.fields.year   = yr;
    r.fields.month  = mo;
    r.fields.day    = dy;
    r.fields.hour   = hr;
    r.fields.minute = mi;
    r.fields.second = se;
    return r;
  endfunction

  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_JUNK  = 8'hFF;

  // Directed strings: empty string, saturated year, every separator with
  // zero month/day and fields past second, then an unparsable byte behind an
  // ignored no-byte request.
  script_row_t script [SCRIPT_LEN] = '{
    '{'{CH_NUL,   1'b1, 1'b1}, 1'b1, date_of(1'b0, -32'sd1900, 31'd0, 31'd1, 31'd0, 31'd0, 31'd0)},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NINE,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NUL,   1'b1, 1'b1}, 1'b1,
      date_of(1'b0, 32'd2147481747, 31'd0, 31'd1, 31'd0, 31'd0, 31'd0)},
    '{'{CH_FIVE,    1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_DASH,    1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_DOT,     1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_SPACE,   1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_COLON,   1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NEWLINE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_NUL,     1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_SEVEN,   1'b1, 1'b0}, 1'b1,
      date_of(1'b0, -32'sd1895, 31'd0, 31'd1, 31'd0, 31'd0, 31'd0)},
    '{'{CH_JUNK,  1'b0, 1'b1}, 1'b0, '0},
    '{'{CH_JUNK,  1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_ONE,   1'b1, 1'b0}, 1'b1, date_of(1'b1, 32'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0)}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit splits_field(input logic [7:0] c);
    return c == CH_DASH || c == CH_SPACE || c == CH_COLON || c == CH_DOT ||
           c == CH_NEWLINE || c == CH_NUL;
  endfunction

  // Store the running number into the field that is up next, then clear it.
  function automatic void store_field();
    case (next_field)
      PH_YEAR:   parsed.year   = {1'b0, digits_acc} - YEAR_BASE;
      PH_MONTH:  parsed.month  = (digits_acc == 0) ? 31'd0 : digits_acc - 31'd1;
      PH_DAY:    parsed.day    = (digits_acc == 0) ? 31'd1 : digits_acc;
      PH_HOUR:   parsed.hour   = digits_acc;
      PH_MINUTE: parsed.minute = digits_acc;
      PH_SECOND: parsed.second = digits_acc;
      default: ;
    endcase
    if (next_field != PH_DONE) begin
      next_field = phase_t'(next_field + 3'd1);
    end
    digits_acc = '0;
  endfunction

  // Advance the parse by one accepted request; done marks a finished string.
  function automatic void parse_request(input text_req_t rq, output bit done,
                                        output result_t date);
    logic [34:0] grown;
    done = 1'b0;
    date = '0;
    if (!rq.none && !bad_char) begin
      if (rq.ch >= CH_ZERO && rq.ch <= CH_NINE) begin
        grown = {4'd0, digits_acc} * 35'd10 + {27'd0, rq.ch - CH_ZERO};
        digits_acc = (grown > {4'd0, ACC_MAX}) ? ACC_MAX : grown[30:0];
      end else if (splits_field(rq.ch)) begin
        store_field();
      end else begin
        bad_char = 1'b1;
      end
    end
    if (rq.last) begin
      // End of string closes the open field unless the string is unparsable.
      if (!bad_char) begin
        store_field();
        date.status = 1'b0;
        date.fields = parsed;
      end else begin
        date = '0;
        date.status = 1'b1;
      end
      done       = 1'b1;
      next_field = PH_YEAR;
      digits_acc = '0;
      parsed     = FIELDS_RESET;
      bad_char   = 1'b0;
    end
  endfunction

  // Offer one request after a random gap; hold valid across back-to-back requests.
  task automatic send_request(input text_req_t rq, input logic typed, input result_t want);
    int      gap;
    bit      done;
    result_t date;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, STALL_MAX);
      if ($urandom_range(0, 19) == 0) send_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= rq.ch;
    is_last   <= rq.last;
    no_char   <= rq.none;
    do @(posedge clk); while (!(in_valid && in_ready));
    parse_request(rq, done, date);
    if (done) dates_due.push_back(typed ? want : date);
    if (rq.last || !rq.none) reqs_sent++;
  endtask

  // Drop valid and hold until every owed date has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (dates_due.size() != 0);
  endtask

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 5))
      0: return CH_DASH;
      1: return CH_SPACE;
      2: return CH_COLON;
      3: return CH_DOT;
      4: return CH_NEWLINE;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || splits_field(c));
    return c;
  endfunction

  function automatic void push_char(input logic [7:0] c);
    text.push_back('{c, 1'b0, 1'b0});
  endfunction

  // Build one random string: mostly date-shaped, some with a bad byte, some noise.
  task automatic compose_string();
    int flavor;
    int fields;
    int digits;
    text.delete();
    flavor = $urandom_range(0, 99);
    if (flavor < 15) begin
      repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)));
    end else begin
      fields = $urandom_range(0, 8);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) push_char(pick_separator());
        // Occasionally run long enough to saturate the number.
        digits = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
        repeat (digits) push_char(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 4) == 0) push_char(pick_separator());
      if (flavor < 30) begin
        text.insert($urandom_range(0, text.size()), '{pick_junk(), 1'b0, 1'b0});
      end
    end
    // Close either on the last byte or with a separate no-byte request.
    if (text.size() == 0 || $urandom_range(0, 2) == 0) begin
      text.push_back('{8'($urandom_range(0, 255)), 1'b1, 1'b1});
    end else begin
      text[text.size() - 1].last = 1'b1;
    end
    if ($urandom_range(0, 3) == 0) begin
      text.insert($urandom_range(0, text.size() - 1), '{8'($urandom_range(0, 255)), 1'b0, 1'b1});
    end
  endtask

  // Stimulus: directed table, a drain, then random strings with a mid-run drain.
  initial begin
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) send_request(script[i].req, script[i].typed, script[i].want);
    wait_drained();
    reqs_sent = 0;
    while (reqs_sent < RANDOM_REQS) begin
      if (!drained_mid && reqs_sent >= RANDOM_REQS / 2) begin
        drained_mid = 1'b1;
        wait_drained();
      end
      compose_string();
      foreach (text[i]) send_request(text[i], 1'b0, '0);
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      errors++;
    end
  endtask

  // Result side: random stalls, one long hold-off, check each date as it is taken.
  initial begin
    int      stall;
    bit      held;
    result_t want;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (take_burst > 0) begin
        take_burst--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, STALL_MAX);
        if ($urandom_range(0, 19) == 0) take_burst = $urandom_range(10, 40);
      end
      if (!held && dates_seen >= 30) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      dates_seen++;
      if (dates_due.size() == 0) begin
        $error("date returned with no string pending");
        errors++;
      end else begin
        want = dates_due.pop_front();
        compare_field("status",          {31'd0, want.status},       {31'd0, status});
        compare_field("year_since_1900", want.fields.year,           year_since_1900);
        compare_field("month_index",     {1'b0, want.fields.month},  {1'b0, month_index});
        compare_field("day_of_month",    {1'b0, want.fields.day},    {1'b0, day_of_month});
        compare_field("hour_value",      {1'b0, want.fields.hour},   {1'b0, hour_value});
        compare_field("minute_value",    {1'b0, want.fields.minute}, {1'b0, minute_value});
        compare_field("second_value",    {1'b0, want.fields.second}, {1'b0, second_value});
      end
    end
  end

  // Watchdog: give up after a long stretch with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
